// ===== rtl/core/dcrrq_pkg.sv =====
// Shared types, codes and helpers for the dual-class round-robin queue.
package dcrrq_pkg;

  // Command codes carried in the command field of an input beat.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ENQUEUE = 2'd0;
  localparam cmd_t CMD_DEQUEUE = 2'd1;
  localparam cmd_t CMD_CLEAR   = 2'd2;

  // Protocol number that selects the TCP class.
  localparam logic [7:0] TCP_PROTOCOL = 8'd6;

  // Configuration register map.
  localparam int CFG_ADDR_BITS = 3;
  typedef logic reg_idx_t;
  localparam reg_idx_t REG_BYTE_LIMIT   = 1'b0;
  localparam reg_idx_t REG_PACKET_LIMIT = 1'b1;

  localparam logic [19:0] BYTE_LIMIT_RESET   = 20'd50000;
  localparam logic [6:0]  PACKET_LIMIT_RESET = 7'd0;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // One input beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  protocol;
    logic [15:0] packet_size;
    logic [15:0] packet_tag;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [15:0] out_tag;
    logic [15:0] out_size;
    logic        out_from_tcp;
    logic [7:0]  queued_packets;
    logic [20:0] queued_bytes;
    logic [31:0] drop_count;
    logic [31:0] tcp_yield_count;
    logic [31:0] other_yield_count;
  } result_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } dp_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CAP
  } state_t;

  // Saturating increment of a statistics counter.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/core/dcrrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dcrrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dcrrq_ctrl.sv =====
// Controller state machine that sequences load, execute and capture of each beat.
module dcrrq_ctrl
  import dcrrq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    busy        = 1'b1;
    cmd.load    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.capture = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_CAP: begin
        cmd.capture = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/dcrrq_dp.sv =====
// Datapath: class queues, occupancy tracking, round-robin choice and statistics.
module dcrrq_dp
  import dcrrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  in_item_t    in_item,
  input  logic [19:0] byte_limit,
  input  logic [6:0]  packet_limit,
  output logic        out_strobe,
  output result_t     out_result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int MW = TW + 16;

  // Latched input beat.
  in_item_t item_r;

  // Per-class queue state.
  logic [AW-1:0] tcp_head_r, tcp_head_nxt, oth_head_r, oth_head_nxt;
  logic [CW-1:0] tcp_count_r, tcp_count_nxt, oth_count_r, oth_count_nxt;
  logic [19:0]   tcp_bytes_r, tcp_bytes_nxt, oth_bytes_r, oth_bytes_nxt;
  logic          last_tcp_r, last_tcp_nxt;

  // Statistics.
  logic [31:0] drops_r, drops_nxt;
  logic [31:0] tcp_yields_r, tcp_yields_nxt;
  logic [31:0] oth_yields_r, oth_yields_nxt;

  // Per-beat outcome held between execute and capture.
  logic acc_r, acc_nxt;
  logic deq_valid_r, deq_valid_nxt;
  logic deq_tcp_r, deq_tcp_nxt;

  logic    strobe_r;
  result_t result_r;

  // Memory ports.
  logic          tcp_we, oth_we;
  logic [AW-1:0] wr_slot;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] tcp_rdata, oth_rdata;

  // Enqueue checks on the selected class.
  logic          is_tcp;
  logic [AW-1:0] sel_head;
  logic [CW-1:0] sel_count;
  logic [19:0]   sel_bytes;
  logic          q_full, plim_hit, byte_over, enq_ok;
  logic [AW:0]   tail_sum;

  // Dequeue choice.
  logic use_tcp, pop_ok;

  // Capture path.
  logic [15:0] pop_size;
  logic [15:0] pop_tag;
  logic [CW:0] tot_count;

  function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] h);
    return (h == AW'(QUEUE_DEPTH - 1)) ? '0 : h + AW'(1);
  endfunction

  // Class selection and admission checks.
  always_comb begin
    is_tcp    = (item_r.protocol == TCP_PROTOCOL);
    sel_head  = is_tcp ? tcp_head_r  : oth_head_r;
    sel_count = is_tcp ? tcp_count_r : oth_count_r;
    sel_bytes = is_tcp ? tcp_bytes_r : oth_bytes_r;
    q_full    = (sel_count >= CW'(QUEUE_DEPTH));
    plim_hit  = (packet_limit != 7'd0) && (LW'(sel_count) >= LW'(packet_limit));
    byte_over = ({1'b0, sel_bytes} + 21'(item_r.packet_size)) > {1'b0, byte_limit};
    enq_ok    = !q_full && !plim_hit && !byte_over;
    tail_sum  = (AW + 1)'(sel_head) + (AW + 1)'(sel_count);
    wr_slot   = (tail_sum >= (AW + 1)'(QUEUE_DEPTH)) ?
                AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    wr_data   = {item_r.packet_tag[TW-1:0], item_r.packet_size};
  end

  // Work-conserving round-robin choice.
  always_comb begin
    use_tcp = last_tcp_r ? (oth_count_r == '0) : (tcp_count_r != '0);
    pop_ok  = use_tcp ? (tcp_count_r != '0) : (oth_count_r != '0);
  end

  // Memory write enables.
  assign tcp_we = cmd.exec && (item_r.command == CMD_ENQUEUE) && enq_ok && is_tcp;
  assign oth_we = cmd.exec && (item_r.command == CMD_ENQUEUE) && enq_ok && !is_tcp;

  // Head entry read back after a pop.
  always_comb begin
    pop_size = deq_tcp_r ? tcp_rdata[15:0] : oth_rdata[15:0];
    pop_tag  = deq_tcp_r ? 16'(tcp_rdata[MW-1:16]) : 16'(oth_rdata[MW-1:16]);
  end

  // Next-state logic for queue state and statistics.
  always_comb begin
    tcp_head_nxt   = tcp_head_r;
    oth_head_nxt   = oth_head_r;
    tcp_count_nxt  = tcp_count_r;
    oth_count_nxt  = oth_count_r;
    tcp_bytes_nxt  = tcp_bytes_r;
    oth_bytes_nxt  = oth_bytes_r;
    last_tcp_nxt   = last_tcp_r;
    drops_nxt      = drops_r;
    tcp_yields_nxt = tcp_yields_r;
    oth_yields_nxt = oth_yields_r;
    acc_nxt        = acc_r;
    deq_valid_nxt  = deq_valid_r;
    deq_tcp_nxt    = deq_tcp_r;

    if (cmd.exec) begin
      acc_nxt       = 1'b0;
      deq_valid_nxt = 1'b0;
      deq_tcp_nxt   = 1'b0;
      case (item_r.command)
        CMD_ENQUEUE: begin
          if (enq_ok) begin
            acc_nxt = 1'b1;
            if (is_tcp) begin
              tcp_count_nxt = tcp_count_r + CW'(1);
              tcp_bytes_nxt = tcp_bytes_r + 20'(item_r.packet_size);
            end else begin
              oth_count_nxt = oth_count_r + CW'(1);
              oth_bytes_nxt = oth_bytes_r + 20'(item_r.packet_size);
            end
          end else begin
            drops_nxt = sat_inc(drops_r);
          end
        end
        CMD_DEQUEUE: begin
          if (last_tcp_r && use_tcp) begin
            oth_yields_nxt = sat_inc(oth_yields_r);
          end
          if (!last_tcp_r && !use_tcp) begin
            tcp_yields_nxt = sat_inc(tcp_yields_r);
          end
          last_tcp_nxt  = use_tcp;
          deq_valid_nxt = pop_ok;
          deq_tcp_nxt   = use_tcp;
          if (pop_ok) begin
            if (use_tcp) begin
              tcp_head_nxt  = head_inc(tcp_head_r);
              tcp_count_nxt = tcp_count_r - CW'(1);
            end else begin
              oth_head_nxt  = head_inc(oth_head_r);
              oth_count_nxt = oth_count_r - CW'(1);
            end
          end
        end
        CMD_CLEAR: begin
          drops_nxt      = '0;
          tcp_yields_nxt = '0;
          oth_yields_nxt = '0;
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end

    // Byte counts of a pop drop once the size has come back from memory.
    if (cmd.capture && deq_valid_r) begin
      if (deq_tcp_r) begin
        tcp_bytes_nxt = (tcp_bytes_r >= 20'(pop_size)) ? tcp_bytes_r - 20'(pop_size) : '0;
      end else begin
        oth_bytes_nxt = (oth_bytes_r >= 20'(pop_size)) ? oth_bytes_r - 20'(pop_size) : '0;
      end
    end
  end

  assign tot_count = (CW + 1)'(tcp_count_r) + (CW + 1)'(oth_count_r);

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcp_head_r   <= '0;
      oth_head_r   <= '0;
      tcp_count_r  <= '0;
      oth_count_r  <= '0;
      tcp_bytes_r  <= '0;
      oth_bytes_r  <= '0;
      last_tcp_r   <= 1'b1;
      drops_r      <= '0;
      tcp_yields_r <= '0;
      oth_yields_r <= '0;
      strobe_r     <= 1'b0;
    end else begin
      tcp_head_r   <= tcp_head_nxt;
      oth_head_r   <= oth_head_nxt;
      tcp_count_r  <= tcp_count_nxt;
      oth_count_r  <= oth_count_nxt;
      tcp_bytes_r  <= tcp_bytes_nxt;
      oth_bytes_r  <= oth_bytes_nxt;
      last_tcp_r   <= last_tcp_nxt;
      drops_r      <= drops_nxt;
      tcp_yields_r <= tcp_yields_nxt;
      oth_yields_r <= oth_yields_nxt;
      strobe_r     <= cmd.capture;
    end
  end

  // Payload registers: input beat, outcome flags and the result beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    acc_r       <= acc_nxt;
    deq_valid_r <= deq_valid_nxt;
    deq_tcp_r   <= deq_tcp_nxt;
    if (cmd.capture) begin
      result_r.accepted          <= acc_r;
      result_r.out_valid         <= deq_valid_r;
      result_r.out_tag           <= deq_valid_r ? pop_tag : 16'd0;
      result_r.out_size          <= deq_valid_r ? pop_size : 16'd0;
      result_r.out_from_tcp      <= deq_valid_r && deq_tcp_r;
      result_r.queued_packets    <= 8'(tot_count);
      result_r.queued_bytes      <= 21'(tcp_bytes_nxt) + 21'(oth_bytes_nxt);
      result_r.drop_count        <= drops_r;
      result_r.tcp_yield_count   <= tcp_yields_r;
      result_r.other_yield_count <= oth_yields_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

  // Descriptor memories; each reads its own head entry every cycle.
  dcrrq_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_tcp_ram (
    .clk   (clk),
    .we    (tcp_we),
    .waddr (wr_slot),
    .wdata (wr_data),
    .raddr (tcp_head_r),
    .rdata (tcp_rdata)
  );

  dcrrq_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_oth_ram (
    .clk   (clk),
    .we    (oth_we),
    .waddr (wr_slot),
    .wdata (wr_data),
    .raddr (oth_head_r),
    .rdata (oth_rdata)
  );

  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tcp_count_r <= CW'(QUEUE_DEPTH)) && (oth_count_r <= CW'(QUEUE_DEPTH)))
    else $error("queue occupancy above depth");

  // A successful pop lowers the total occupancy by exactly one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (item_r.command == CMD_DEQUEUE) && pop_ok |=>
      tot_count == $past(tot_count) - (CW + 1)'(1))
    else $error("pop did not remove exactly one packet");

  // A result beat is only captured right after an execute cycle.
  a_capture_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> $past(cmd.exec))
    else $error("capture without preceding execute");

  // Memory writes only happen on an accepted enqueue into a queue with room.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    (tcp_we || oth_we) |-> !q_full && cmd.exec)
    else $error("descriptor write into a full queue");

endmodule

// ===== rtl/core/dual_class_round_robin_queue_core.sv =====
// Top level: configuration registers, controller and datapath of the two-class queue.
// An accepted command passes through the execute state and then the capture state, which
// waits for the registered read of the descriptor memory; the result strobe is registered
// from capture. busy stays high in both states, so a new command waits for the last.
// Reset: both queues empty, counters zero, round robin starts as if TCP was last served,
// byte limit 50000 and packet limit 0; the memories need no clearing pass.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module dual_class_round_robin_queue_core
  import dcrrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_item,
  output logic                     out_strobe,
  output result_t                  out_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [19:0] byte_limit_r;
  logic [6:0]  packet_limit_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  dp_cmd_t     dp_cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r   <= BYTE_LIMIT_RESET;
      packet_limit_r <= PACKET_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BYTE_LIMIT:   byte_limit_r   <= pwdata[19:0];
        REG_PACKET_LIMIT: packet_limit_r <= pwdata[6:0];
        default: begin
          byte_limit_r <= byte_limit_r;
        end
      endcase
    end
  end

  // Configuration register readback.
  always_comb begin
    case (cfg_idx)
      REG_BYTE_LIMIT:   prdata = {12'd0, byte_limit_r};
      REG_PACKET_LIMIT: prdata = {25'd0, packet_limit_r};
      default:          prdata = 32'd0;
    endcase
  end

  dcrrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (dp_cmd)
  );

  dcrrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .in_item      (in_item),
    .byte_limit   (byte_limit_r),
    .packet_limit (packet_limit_r),
    .out_strobe   (out_strobe),
    .out_result   (out_result)
  );

endmodule

// ===== sim/dcrrq_result_checker.sv =====
// Result checker for the dual-class round-robin queue: predicts every result beat and compares it.
`timescale 1ns / 1ps

module dcrrq_result_checker
  import dcrrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  in_item_t                 in_item,
  input  logic                     out_strobe,
  input  result_t                  out_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       served,
  output int                       dropped
);

  localparam logic [CFG_ADDR_BITS-1:0] BYTE_LIMIT_ADDR   = {REG_BYTE_LIMIT, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] PACKET_LIMIT_ADDR = {REG_PACKET_LIMIT, 2'b00};

  // One queued packet descriptor.
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] size;
  } descriptor_t;

  // Predicted queue contents, byte totals, round-robin turn and statistics.
  descriptor_t tcp_q[$];
  descriptor_t other_q[$];
  logic [19:0] tcp_bytes;
  logic [19:0] other_bytes;
  logic        tcp_served_last;
  logic [31:0] drops;
  logic [31:0] tcp_yields;
  logic [31:0] other_yields;
  logic [19:0] byte_limit;
  logic [6:0]  packet_limit;

  // Results still owed by the block, oldest first.
  result_t expected_results[$];

  // Statistics counters stick at their maximum.
  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // A class queue takes a packet only if depth, packet limit and byte limit all allow it.
  function automatic logic room_for(input int count, input logic [19:0] bytes,
                                    input logic [15:0] size);
    if (count >= QUEUE_DEPTH) return 1'b0;
    if (packet_limit != 7'd0 && count >= int'(packet_limit)) return 1'b0;
    return (21'(bytes) + 21'(size)) <= 21'(byte_limit);
  endfunction

  // Applies one command beat to the predicted state and returns the result it causes.
  function automatic result_t apply_command(input in_item_t cmd);
    result_t     r;
    descriptor_t d;
    logic        is_tcp;
    logic        ok;
    logic        use_tcp;
    r = '0;
    case (cmd.command)
      CMD_ENQUEUE: begin
        is_tcp = (cmd.protocol == TCP_PROTOCOL);
        if (is_tcp) ok = room_for(tcp_q.size(), tcp_bytes, cmd.packet_size);
        else ok = room_for(other_q.size(), other_bytes, cmd.packet_size);
        d.tag  = cmd.packet_tag;
        d.size = cmd.packet_size;
        if (!ok) begin
          drops = bump(drops);
          dropped++;
        end else begin
          r.accepted = 1'b1;
          if (is_tcp) begin
            tcp_q.push_back(d);
            tcp_bytes = tcp_bytes + 20'(cmd.packet_size);
          end else begin
            other_q.push_back(d);
            other_bytes = other_bytes + 20'(cmd.packet_size);
          end
        end
      end
      CMD_DEQUEUE: begin
        // Work-conserving alternation: an empty class gives up its turn.
        if (tcp_served_last) begin
          use_tcp = (other_q.size() == 0);
          if (use_tcp) other_yields = bump(other_yields);
        end else begin
          use_tcp = (tcp_q.size() != 0);
          if (!use_tcp) tcp_yields = bump(tcp_yields);
        end
        tcp_served_last = use_tcp;
        if (use_tcp && tcp_q.size() != 0) begin
          d = tcp_q.pop_front();
          tcp_bytes = (tcp_bytes >= 20'(d.size)) ? tcp_bytes - 20'(d.size) : 20'd0;
          r.out_from_tcp = 1'b1;
          r.out_valid    = 1'b1;
        end else if (!use_tcp && other_q.size() != 0) begin
          d = other_q.pop_front();
          other_bytes = (other_bytes >= 20'(d.size)) ? other_bytes - 20'(d.size) : 20'd0;
          r.out_valid = 1'b1;
        end
        if (r.out_valid) begin
          r.out_tag  = d.tag;
          r.out_size = d.size;
          served++;
        end
      end
      CMD_CLEAR: begin
        drops        = '0;
        tcp_yields   = '0;
        other_yields = '0;
      end
      default: ;
    endcase
    r.queued_packets    = 8'(tcp_q.size() + other_q.size());
    r.queued_bytes      = 21'(tcp_bytes) + 21'(other_bytes);
    r.drop_count        = drops;
    r.tcp_yield_count   = tcp_yields;
    r.other_yield_count = other_yields;
    return r;
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin : watch
    result_t want;
    string   diffs;
    if (!rst_n) begin
      tcp_q.delete();
      other_q.delete();
      expected_results.delete();
      tcp_bytes       = '0;
      other_bytes     = '0;
      tcp_served_last = 1'b1;
      drops           = '0;
      tcp_yields      = '0;
      other_yields    = '0;
      byte_limit      = BYTE_LIMIT_RESET;
      packet_limit    = PACKET_LIMIT_RESET;
      fail_count      = 0;
      checked         = 0;
      served          = 0;
      dropped         = 0;
    end else begin
      // Compare a result beat with the oldest outstanding prediction.
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with no command outstanding: %h", $time, out_result);
        end else begin
          want  = expected_results.pop_front();
          diffs = "";
          checked++;
          if (out_result.accepted !== want.accepted)
            diffs = {diffs, $sformatf(" accepted exp %0d got %0d",
                                      want.accepted, out_result.accepted)};
          if (out_result.out_valid !== want.out_valid)
            diffs = {diffs, $sformatf(" out_valid exp %0d got %0d",
                                      want.out_valid, out_result.out_valid)};
          if (out_result.out_tag !== want.out_tag)
            diffs = {diffs, $sformatf(" out_tag exp %h got %h",
                                      want.out_tag, out_result.out_tag)};
          if (out_result.out_size !== want.out_size)
            diffs = {diffs, $sformatf(" out_size exp %0d got %0d",
                                      want.out_size, out_result.out_size)};
          if (out_result.out_from_tcp !== want.out_from_tcp)
            diffs = {diffs, $sformatf(" out_from_tcp exp %0d got %0d",
                                      want.out_from_tcp, out_result.out_from_tcp)};
          if (out_result.queued_packets !== want.queued_packets)
            diffs = {diffs, $sformatf(" queued_packets exp %0d got %0d",
                                      want.queued_packets, out_result.queued_packets)};
          if (out_result.queued_bytes !== want.queued_bytes)
            diffs = {diffs, $sformatf(" queued_bytes exp %0d got %0d",
                                      want.queued_bytes, out_result.queued_bytes)};
          if (out_result.drop_count !== want.drop_count)
            diffs = {diffs, $sformatf(" drop_count exp %0d got %0d",
                                      want.drop_count, out_result.drop_count)};
          if (out_result.tcp_yield_count !== want.tcp_yield_count)
            diffs = {diffs, $sformatf(" tcp_yield_count exp %0d got %0d",
                                      want.tcp_yield_count, out_result.tcp_yield_count)};
          if (out_result.other_yield_count !== want.other_yield_count)
            diffs = {diffs, $sformatf(" other_yield_count exp %0d got %0d",
                                      want.other_yield_count, out_result.other_yield_count)};
          if (diffs != "") begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result beat %0d mismatch:%s", $time, checked, diffs);
          end
        end
      end

      // Track register writes so the prediction uses the live limits.
      if (psel && penable && pwrite && pready) begin
        if (paddr == BYTE_LIMIT_ADDR) byte_limit = pwdata[19:0];
        else if (paddr == PACKET_LIMIT_ADDR) packet_limit = pwdata[6:0];
      end

      // Every accepted command beat yields exactly one result.
      if (start && !busy) expected_results.push_back(apply_command(in_item));
    end
    pending = expected_results.size();
  end

endmodule

// ===== sim/dual_class_round_robin_queue_core_tb.sv =====
// Testbench top for the dual-class round-robin queue: drives commands and limits, gives the verdict.
`timescale 1ns / 1ps

module dual_class_round_robin_queue_core_tb;
  import dcrrq_pkg::*;

  localparam int   QUEUE_DEPTH    = 64;
  localparam int   WATCHDOG_LIMIT = 500;
  localparam int   PHASES         = 7;
  localparam int   PHASE_ITEMS    = 120;
  localparam cmd_t CMD_UNUSED     = 2'd3;
  localparam logic [CFG_ADDR_BITS-1:0] BYTE_LIMIT_ADDR   = {REG_BYTE_LIMIT, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] PACKET_LIMIT_ADDR = {REG_PACKET_LIMIT, 2'b00};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_item_t                 in_item;
  logic                     out_strobe;
  result_t                  out_result;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int checked;
  int served;
  int dropped;
  int sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  dual_class_round_robin_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (16)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  dcrrq_result_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .served    (served),
    .dropped   (dropped)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort when no beat, result or register write has moved for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t beat(input cmd_t cmd, input logic [7:0] proto,
                                    input logic [15:0] size, input logic [15:0] tag);
    in_item_t b;
    b.command     = cmd;
    b.protocol    = proto;
    b.packet_size = size;
    b.packet_tag  = tag;
    return b;
  endfunction

  // Offer one command beat and hold it until the block takes it; then maybe pause.
  task automatic send_command(input in_item_t cmd);
    logic taken;
    start   <= 1'b1;
    in_item <= cmd;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup and access cycle of one register write, then the bus goes idle.
  task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr, input logic [31:0] val);
    logic ready_seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = pready;
      @(posedge clk);
    end while (!ready_seen);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          enq_pct;
    int          tcp_pct;
    int          pick;
    logic [19:0] blim;
    logic [6:0]  plim;
    in_item_t    cmd;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset limits: dequeue with both queues empty, byte limit
    // overrun and exact fit, zero-size packet, protocols next to 6, both give-up
    // directions, clearing the counters and the unused command code.
    send_command(beat(CMD_DEQUEUE, 8'd0, 16'd0, 16'd0));
    send_command(beat(CMD_ENQUEUE, TCP_PROTOCOL, 16'hFFFF, 16'hFFFF));
    send_command(beat(CMD_ENQUEUE, TCP_PROTOCOL, 16'd50000, 16'h1234));
    send_command(beat(CMD_ENQUEUE, TCP_PROTOCOL, 16'd1, 16'h0001));
    send_command(beat(CMD_ENQUEUE, TCP_PROTOCOL, 16'd0, 16'h0000));
    send_command(beat(CMD_ENQUEUE, 8'd0, 16'd100, 16'h0005));
    send_command(beat(CMD_ENQUEUE, 8'hFF, 16'd1, 16'hFFFF));
    send_command(beat(CMD_ENQUEUE, 8'd7, 16'd2, 16'hA5A5));
    send_command(beat(CMD_ENQUEUE, 8'd5, 16'd3, 16'h5A5A));
    repeat (8) send_command(beat(CMD_DEQUEUE, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_command(beat(CMD_UNUSED, TCP_PROTOCOL, 16'hFFFF, 16'hFFFF));
    send_command(beat(CMD_CLEAR, 8'd0, 16'd0, 16'd0));
    send_command(beat(CMD_UNUSED, 8'd0, 16'd0, 16'd0));

    // Random phases, each under its own limits; queued packets carry over so that
    // lowered limits meet full queues.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin blim = 20'hFFFFF; plim = 7'd0;   enq_pct = 92; tcp_pct = 70; end
        1: begin blim = 20'hFFFFF; plim = 7'd127; enq_pct = 60; tcp_pct = 70; end
        2: begin blim = 20'd0;     plim = 7'd0;   enq_pct = 50; tcp_pct = 50; end
        3: begin blim = 20'd20000; plim = 7'd5;   enq_pct = 55; tcp_pct = 50; end
        4: begin blim = 20'hFFFFF; plim = 7'd1;   enq_pct = 50; tcp_pct = 50; end
        5: begin blim = 20'd300000; plim = 7'd64; enq_pct = 85; tcp_pct = 30; end
        default: begin
          blim = BYTE_LIMIT_RESET; plim = PACKET_LIMIT_RESET; enq_pct = 45; tcp_pct = 50;
        end
      endcase
      drain_results();
      write_register(BYTE_LIMIT_ADDR, 32'(blim));
      write_register(PACKET_LIMIT_ADDR, 32'(plim));
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < enq_pct) cmd.command = CMD_ENQUEUE;
        else if (pick < 94) cmd.command = CMD_DEQUEUE;
        else if (pick < 97) cmd.command = CMD_CLEAR;
        else cmd.command = CMD_UNUSED;
        cmd.protocol = ($urandom_range(99) < tcp_pct) ? TCP_PROTOCOL : 8'($urandom_range(255));
        // Mostly small packets, some of any length, a few of zero length.
        pick = $urandom_range(99);
        if (pick < 5) cmd.packet_size = 16'd0;
        else if (pick < 75) cmd.packet_size = 16'($urandom_range(1, 2000));
        else cmd.packet_size = 16'($urandom_range(1, 65535));
        cmd.packet_tag = 16'($urandom);
        send_command(cmd);
      end
    end
    drain_results();
    @(negedge clk);

    $display("Sent %0d commands under %0d limit settings, byte and packet limit extremes included.",
             sent, PHASES + 1);
    $display("Checked %0d result beats: %0d packets dequeued, %0d enqueues dropped.",
             checked, served, dropped);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
